>>> rtl/acc_alu_pkg.sv
package acc_alu_pkg;

	localparam int NUM_REGS  = 8;
	localparam int MEM_WORDS = 256;
	localparam int DATA_W    = 32;
	localparam int REG_AW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam int DIV_STEPS = DATA_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		OP_MOV = 3'd0,
		OP_ADD = 3'd1,
		OP_SUB = 3'd2,
		OP_MUL = 3'd3,
		OP_DIV = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		MD_REG = 2'd0,
		MD_MEM = 2'd1,
		MD_IMM = 2'd2,
		MD_UNK = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FIRST   = 3'd1,
		ST_SECOND  = 3'd2,
		ST_DIVZERO = 3'd3,
		ST_REFUSED = 3'd4
	} status_t;

	typedef struct packed {
		logic              rf_en;
		logic              mem_en;
		logic [REG_AW-1:0] rf_addr;
		logic [MEM_AW-1:0] mem_addr;
		logic [DATA_W-1:0] data;
	} wr_req_t;

endpackage

>>> rtl/acc_alu_req_if.sv
interface acc_alu_req_if import acc_alu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [2:0]               opcode;
	logic [1:0]               first_mode;
	logic signed [DATA_W-1:0] first_value;
	logic [1:0]               second_mode;
	logic signed [DATA_W-1:0] second_value;

	modport source (
		output valid, opcode, first_mode, first_value, second_mode, second_value,
		input  ready
	);

	modport sink (
		input  valid, opcode, first_mode, first_value, second_mode, second_value,
		output ready
	);
endinterface

>>> rtl/acc_alu_rsp_if.sv
interface acc_alu_rsp_if import acc_alu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     success;
	logic [2:0]               status;
	logic signed [DATA_W-1:0] written_value;

	modport source (
		output valid, success, status, written_value,
		input  ready
	);

	modport sink (
		input  valid, success, status, written_value,
		output ready
	);
endinterface

>>> rtl/acc_alu_store.sv
module acc_alu_store import acc_alu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [REG_AW-1:0] rf_raddr,
	input  logic [MEM_AW-1:0] mem_raddr,
	input  wr_req_t           wr,
	output logic [DATA_W-1:0] rf_rdata,
	output logic [DATA_W-1:0] mem_rdata
);

	logic [DATA_W-1:0] rf_q [NUM_REGS];
	logic [DATA_W-1:0] mem_q [MEM_WORDS];
	logic [NUM_REGS-1:0]  rf_vld_q;
	logic [MEM_WORDS-1:0] mem_vld_q;
	logic [DATA_W-1:0] rf_rdata_q;
	logic [DATA_W-1:0] mem_rdata_q;

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q  <= '0;
			mem_vld_q <= '0;
		end else begin
			if (wr.rf_en)
				rf_vld_q[wr.rf_addr] <= 1'b1;
			if (wr.mem_en)
				mem_vld_q[wr.mem_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.rf_en)
			rf_q[wr.rf_addr] <= wr.data;
		rf_rdata_q <= rf_vld_q[rf_raddr] ? rf_q[rf_raddr] : '0;
	end

	always_ff @(posedge clk) begin
		if (wr.mem_en)
			mem_q[wr.mem_addr] <= wr.data;
		mem_rdata_q <= mem_vld_q[mem_raddr] ? mem_q[mem_raddr] : '0;
	end

	assign rf_rdata  = rf_rdata_q;
	assign mem_rdata = mem_rdata_q;

endmodule

>>> rtl/accumulator_alu_with_operand_modes.sv
// Accumulator ALU with register, memory and immediate operands.
// req: one instruction per beat (opcode, two operand modes and values).
// rsp: one result beat per instruction (success, status, written_value).
// An instruction is taken only while the block is idle; req.ready drops
// until its result has been loaded into the output register.
// Each instruction steps through S_RDA, S_RDB, S_EXEC and S_WB; divide by
// a nonzero divisor adds S_DIV before S_WB, and a failed operand check goes
// from S_RDA straight to S_WB. Divide runs the restoring divider loop, one
// quotient bit a cycle on the shared 33-bit adder. Operands are read one per
// cycle from the register file and data memory through registered read ports.
// The output register holds a result until rsp.ready; while it is full a
// finished instruction waits in the write-back step, and nothing is
// written until the result can be handed over.
// Reset clears the register file and data memory to zero (per-entry valid
// bits) and leaves the block idle with no result pending.
module accumulator_alu_with_operand_modes import acc_alu_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	acc_alu_req_if.sink   req,
	acc_alu_rsp_if.source rsp
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RDA  = 6'b000010,
		S_RDB  = 6'b000100,
		S_EXEC = 6'b001000,
		S_DIV  = 6'b010000,
		S_WB   = 6'b100000
	} state_t;

	state_t            state_q;
	logic [2:0]        opcode_q;
	logic [1:0]        mode1_q;
	logic [1:0]        mode2_q;
	logic [DATA_W-1:0] val1_q;
	logic [DATA_W-1:0] val2_q;
	logic [DATA_W-1:0] a_q;
	logic [DATA_W-1:0] res_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;
	status_t           status_q;

	logic              rsp_valid_q;
	logic              success_q;
	logic [2:0]        rsp_status_q;
	logic [DATA_W-1:0] written_q;

	logic [REG_AW-1:0] rf_raddr;
	logic [MEM_AW-1:0] mem_raddr;
	logic [DATA_W-1:0] rf_rdata;
	logic [DATA_W-1:0] mem_rdata;
	wr_req_t           wr;

	status_t           chk;
	logic [DATA_W-1:0] b_cur;
	logic [DATA_W-1:0] prod;
	logic [DATA_W-1:0] mag_a;
	logic [DATA_W-1:0] mag_b;
	logic [DATA_W-1:0] wdata;
	logic [DATA_W:0]   add_x;
	logic [DATA_W:0]   add_y;
	logic              add_cin;
	logic [DATA_W+1:0] sum;
	logic              slot_free;
	logic              accept;
	logic              is_div;

	function automatic logic opnd_ok(input logic [1:0] mode, input logic [DATA_W-1:0] v);
		logic ok;
		case (mode)
			MD_REG:  ok = (v < DATA_W'(NUM_REGS));
			MD_MEM:  ok = (v < DATA_W'(MEM_WORDS));
			MD_IMM:  ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	function automatic logic [DATA_W-1:0] pick(input logic [1:0] mode,
			input logic [DATA_W-1:0] imm, input logic [DATA_W-1:0] rfd,
			input logic [DATA_W-1:0] memd);
		logic [DATA_W-1:0] r;
		case (mode)
			MD_REG:  r = rfd;
			MD_MEM:  r = memd;
			default: r = imm;
		endcase
		return r;
	endfunction

	acc_alu_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rf_raddr  (rf_raddr),
		.mem_raddr (mem_raddr),
		.wr        (wr),
		.rf_rdata  (rf_rdata),
		.mem_rdata (mem_rdata)
	);

	assign accept    = req.valid && req.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign is_div    = (opcode_q == OP_DIV);

	// first operand is read in S_RDA, second in S_RDB
	assign rf_raddr  = (state_q == S_RDA) ? val1_q[REG_AW-1:0] : val2_q[REG_AW-1:0];
	assign mem_raddr = (state_q == S_RDA) ? val1_q[MEM_AW-1:0] : val2_q[MEM_AW-1:0];

	assign b_cur = pick(mode2_q, val2_q, rf_rdata, mem_rdata);
	assign prod  = a_q * b_cur;
	assign mag_a = a_q[DATA_W-1] ? (~a_q + DATA_W'(1)) : a_q;
	assign mag_b = b_cur[DATA_W-1] ? (~b_cur + DATA_W'(1)) : b_cur;

	always_comb begin
		chk = ST_OK;
		if (opcode_q > OP_DIV)
			chk = ST_REFUSED;
		else if (opcode_q == OP_MOV) begin
			if (!opnd_ok(mode2_q, val2_q))
				chk = ST_SECOND;
			else if (mode1_q == MD_REG || mode1_q == MD_MEM) begin
				if (!opnd_ok(mode1_q, val1_q))
					chk = ST_REFUSED;
			end else
				chk = ST_FIRST;
		end else if (!opnd_ok(mode1_q, val1_q))
			chk = ST_FIRST;
		else if (!opnd_ok(mode2_q, val2_q))
			chk = ST_SECOND;
	end

	// shared adder: add/sub, divider trial subtract, quotient negate
	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_cin = 1'b0;
		case (state_q)
			S_EXEC: begin
				add_x   = {1'b0, a_q};
				add_cin = (opcode_q == OP_SUB);
				add_y   = {1'b0, add_cin ? ~b_cur : b_cur};
			end
			S_DIV: begin
				add_x   = {rem_q, quo_q[DATA_W-1]};
				add_y   = ~{1'b0, dvs_q};
				add_cin = 1'b1;
			end
			S_WB: begin
				add_y   = ~{1'b0, quo_q};
				add_cin = 1'b1;
			end
			default: ;
		endcase
		sum = {1'b0, add_x} + {1'b0, add_y} + {{(DATA_W+1){1'b0}}, add_cin};
	end

	assign wdata = is_div ? (neg_q ? sum[DATA_W-1:0] : quo_q) : res_q;

	always_comb begin
		wr          = '0;
		wr.data     = wdata;
		wr.rf_addr  = (opcode_q == OP_MOV) ? val1_q[REG_AW-1:0] : '0;
		wr.mem_addr = val1_q[MEM_AW-1:0];
		if (state_q == S_WB && slot_free && status_q == ST_OK) begin
			wr.rf_en  = (opcode_q != OP_MOV) || (mode1_q == MD_REG);
			wr.mem_en = (opcode_q == OP_MOV) && (mode1_q == MD_MEM);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (accept) state_q <= S_RDA;
				S_RDA:  state_q <= (chk == ST_OK) ? S_RDB : S_WB;
				S_RDB:  state_q <= S_EXEC;
				S_EXEC: state_q <= (is_div && b_cur != '0) ? S_DIV : S_WB;
				S_DIV:  if (cnt_q == '0) state_q <= S_WB;
				S_WB:   if (slot_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_WB && slot_free)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (accept) begin
				opcode_q <= req.opcode;
				mode1_q  <= req.first_mode;
				val1_q   <= req.first_value;
				mode2_q  <= req.second_mode;
				val2_q   <= req.second_value;
			end
			S_RDA: status_q <= chk;
			S_RDB: a_q <= pick(mode1_q, val1_q, rf_rdata, mem_rdata);
			S_EXEC: begin
				case (opcode_q)
					OP_MOV:  res_q <= b_cur;
					OP_MUL:  res_q <= prod;
					default: res_q <= sum[DATA_W-1:0];
				endcase
				if (is_div && b_cur == '0)
					status_q <= ST_DIVZERO;
				quo_q <= mag_a;
				dvs_q <= mag_b;
				rem_q <= '0;
				neg_q <= a_q[DATA_W-1] ^ b_cur[DATA_W-1];
				cnt_q <= CNT_W'(DIV_STEPS - 1);
			end
			S_DIV: begin
				rem_q <= sum[DATA_W+1] ? sum[DATA_W-1:0] : {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
				quo_q <= {quo_q[DATA_W-2:0], sum[DATA_W+1]};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			S_WB: if (slot_free) begin
				success_q    <= (status_q == ST_OK);
				rsp_status_q <= status_q;
				written_q    <= (status_q == ST_OK) ? wdata : '0;
			end
			default: ;
		endcase
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.success       = success_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.written_value = written_q;

`ifndef ASSERT_OFF
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_RDA)
		else $error("accepted beat did not start operand read");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == '0) |=> state_q == S_WB)
		else $error("divider did not finish after last step");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.success) |-> rsp.written_value == '0)
		else $error("failed result carries a nonzero value");

	a_success_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.success == (rsp.status == ST_OK)))
		else $error("success flag disagrees with status");

	a_no_write_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.rf_en || wr.mem_en) |-> (state_q == S_WB && status_q == ST_OK))
		else $error("store written outside a successful write-back");
`endif

endmodule

>>> verif/accumulator_alu_with_operand_modes_tb.sv
module accumulator_alu_with_operand_modes_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import acc_alu_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 800000;
	localparam int unsigned SETTLE_CYCLES = 48;
	localparam int unsigned MAX_REPORTS  = 10;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [1:0]  first_mode;
		logic [31:0] first_value;
		logic [1:0]  second_mode;
		logic [31:0] second_value;
	} instr_t;

	typedef struct packed {
		logic        success;
		status_t     status;
		logic [31:0] value;
	} outcome_t;

	logic clk;
	logic arst_n;
	logic steady;

	acc_alu_req_if req();
	acc_alu_rsp_if rsp();

	accumulator_alu_with_operand_modes u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	logic [31:0] reg_shadow [NUM_REGS];
	logic [31:0] mem_shadow [MEM_WORDS];
	outcome_t    pending_q[$];
	int unsigned bad_beats;
	int unsigned cycles;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	// operand read; 0 when mode or index is bad
	function automatic logic fetch_operand(input logic [1:0] md, input logic [31:0] v,
			output logic [31:0] data);
		data = '0;
		case (md)
			MD_REG: begin
				if (v >= 32'(NUM_REGS))
					return 1'b0;
				data = reg_shadow[v[REG_AW-1:0]];
			end
			MD_MEM: begin
				if (v >= 32'(MEM_WORDS))
					return 1'b0;
				data = mem_shadow[v[MEM_AW-1:0]];
			end
			MD_IMM: data = v;
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic outcome_t execute_instr(input instr_t ins);
		logic [31:0] a, b, r, mag_a, mag_b, quo;
		outcome_t    res;
		res.success = 1'b0;
		res.status  = ST_REFUSED;
		res.value   = '0;
		a = '0;
		b = '0;
		r = '0;
		if (ins.opcode > OP_DIV)
			return res;
		if (ins.opcode == OP_MOV) begin
			if (!fetch_operand(ins.second_mode, ins.second_value, b)) begin
				res.status = ST_SECOND;
				return res;
			end
			if (ins.first_mode == MD_REG) begin
				if (ins.first_value >= 32'(NUM_REGS))
					return res;
				reg_shadow[ins.first_value[REG_AW-1:0]] = b;
			end else if (ins.first_mode == MD_MEM) begin
				if (ins.first_value >= 32'(MEM_WORDS))
					return res;
				mem_shadow[ins.first_value[MEM_AW-1:0]] = b;
			end else begin
				res.status = ST_FIRST;
				return res;
			end
			r = b;
		end else begin
			if (!fetch_operand(ins.first_mode, ins.first_value, a)) begin
				res.status = ST_FIRST;
				return res;
			end
			if (!fetch_operand(ins.second_mode, ins.second_value, b)) begin
				res.status = ST_SECOND;
				return res;
			end
			case (ins.opcode)
				OP_ADD: r = a + b;
				OP_SUB: r = a - b;
				OP_MUL: r = a * b;
				default: begin
					if (b == 32'd0) begin
						res.status = ST_DIVZERO;
						return res;
					end
					// truncate toward zero; MIN / -1 wraps back to MIN
					mag_a = a[31] ? 32'd0 - a : a;
					mag_b = b[31] ? 32'd0 - b : b;
					quo   = mag_a / mag_b;
					r     = (a[31] ^ b[31]) ? 32'd0 - quo : quo;
				end
			endcase
			reg_shadow[0] = r;
		end
		res.success = 1'b1;
		res.status  = ST_OK;
		res.value   = r;
		return res;
	endfunction

	task automatic send_instr(input logic [2:0] op, input logic [1:0] m1, input logic [31:0] v1,
			input logic [1:0] m2, input logic [31:0] v2);
		instr_t      ins;
		int unsigned gap;
		ins = '{op, m1, v1, m2, v2};
		req.valid        <= 1'b1;
		req.opcode       <= op;
		req.first_mode   <= m1;
		req.first_value  <= v1;
		req.second_mode  <= m2;
		req.second_value <= v2;
		do @(posedge clk); while (!req.ready);
		pending_q.push_back(execute_instr(ins));
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_all_results();
		req.valid <= 1'b0;
		do @(posedge clk); while (pending_q.size() != 0);
	endtask

	task automatic test_moves();
		send_instr(OP_MOV, MD_REG, 1, MD_IMM, 32'h7FFF_FFFF);
		send_instr(OP_MOV, MD_REG, 7, MD_IMM, 32'h8000_0000);
		send_instr(OP_MOV, MD_MEM, 0, MD_IMM, 32'hFFFF_FFFF);
		send_instr(OP_MOV, MD_MEM, MEM_WORDS - 1, MD_REG, 7);
		send_instr(OP_MOV, MD_REG, 2, MD_MEM, MEM_WORDS - 1);
	endtask

	task automatic test_arith_wrap();
		send_instr(OP_ADD, MD_REG, 1, MD_IMM, 1);
		send_instr(OP_SUB, MD_IMM, 32'h8000_0000, MD_IMM, 1);
		send_instr(OP_MUL, MD_MEM, MEM_WORDS - 1, MD_IMM, 32'hFFFF_FFFF);
		send_instr(OP_MUL, MD_IMM, 32'h7FFF_FFFF, MD_REG, 1);
	endtask

	task automatic test_divide();
		send_instr(OP_DIV, MD_REG, 7, MD_IMM, 32'hFFFF_FFFF);
		send_instr(OP_DIV, MD_IMM, -7, MD_IMM, 2);
		send_instr(OP_DIV, MD_IMM, 7, MD_IMM, -2);
		send_instr(OP_DIV, MD_IMM, 5, MD_REG, 6);
		send_instr(OP_DIV, MD_MEM, 0, MD_IMM, 32'h8000_0000);
	endtask

	task automatic test_bad_operands();
		send_instr(OP_ADD, MD_UNK, 0, MD_IMM, 1);
		send_instr(OP_SUB, MD_REG, NUM_REGS, MD_IMM, 1);
		send_instr(OP_MUL, MD_REG, 32'hFFFF_FFFF, MD_IMM, 3);
		send_instr(OP_ADD, MD_IMM, 1, MD_MEM, MEM_WORDS);
		send_instr(OP_DIV, MD_UNK, 9, MD_IMM, 0);
		send_instr(OP_MOV, MD_IMM, 3, MD_UNK, 0);
		send_instr(OP_MOV, MD_IMM, 3, MD_IMM, 5);
		send_instr(OP_MOV, MD_UNK, 0, MD_IMM, 5);
		send_instr(OP_MOV, MD_REG, NUM_REGS, MD_IMM, 5);
		send_instr(OP_MOV, MD_MEM, 32'hFFFF_FFFF, MD_IMM, 5);
	endtask

	task automatic test_bad_opcodes();
		for (int code = int'(OP_DIV) + 1; code < 8; code++)
			send_instr(3'(code), MD_IMM, $urandom, MD_REG, 0);
	endtask

	function automatic logic [1:0] pick_mode(input logic is_dest);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (is_dest)
			return roll < 45 ? MD_REG : roll < 92 ? MD_MEM : roll < 96 ? MD_IMM : MD_UNK;
		return roll < 35 ? MD_REG : roll < 65 ? MD_MEM : roll < 96 ? MD_IMM : MD_UNK;
	endfunction

	function automatic logic [31:0] pick_value(input logic [1:0] md);
		int unsigned roll, pick;
		logic [31:0] wild;
		roll = $urandom_range(0, 99);
		pick = $urandom_range(0, 3);
		wild = pick == 0 ? 32'(NUM_REGS) : pick == 1 ? 32'(MEM_WORDS) :
			pick == 2 ? 32'hFFFF_FFFF : $urandom;
		case (md)
			MD_REG: return roll < 92 ? $urandom_range(0, NUM_REGS - 1) : wild;
			MD_MEM: return roll < 50 ? $urandom_range(0, 15) :
				roll < 92 ? $urandom_range(0, MEM_WORDS - 1) : wild;
			MD_IMM: begin
				if (roll < 20) begin
					case (pick)
						0: return 32'h8000_0000;
						1: return 32'h7FFF_FFFF;
						2: return 32'hFFFF_FFFF;
						default: return $urandom_range(0, 1);
					endcase
				end
				if (roll < 60)
					return 32'($urandom_range(0, 200)) - 32'd100;
				return $urandom;
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic test_random_mix(input int unsigned count);
		int unsigned roll;
		logic [2:0]  op;
		logic [1:0]  m1, m2;
		for (int unsigned n = 0; n < count; n++) begin
			if (n % 60 == 0)
				steady = ($urandom_range(0, 4) == 0);
			roll = $urandom_range(0, 99);
			op = roll < 2 ? 3'($urandom_range(5, 7)) : roll < 35 ? OP_MOV :
				roll < 50 ? OP_ADD : roll < 65 ? OP_SUB : roll < 80 ? OP_MUL : OP_DIV;
			m1 = pick_mode(op == OP_MOV);
			m2 = pick_mode(1'b0);
			send_instr(op, m1, pick_value(m1), m2, pick_value(m2));
		end
		steady = 1'b0;
	endtask

	initial begin : rsp_ready_gen
		int unsigned span;
		rsp.ready = 1'b0;
		@(posedge clk);
		forever begin
			rsp.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			if (!steady) begin
				span = pick_gap();
				if (span != 0) begin
					rsp.ready <= 1'b0;
					repeat (span) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : rsp_check
		outcome_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_q.size() == 0) begin
				if (bad_beats < MAX_REPORTS)
					$display("unexpected result beat: success=%0b status=%0d value=%h",
						rsp.success, rsp.status, rsp.written_value);
				bad_beats++;
			end else begin
				want = pending_q.pop_front();
				if (rsp.success !== want.success || rsp.status !== want.status ||
						rsp.written_value !== want.value) begin
					if (bad_beats < MAX_REPORTS)
						$display("result mismatch: expected %0b/%0d/%h, got %0b/%0d/%h",
							want.success, want.status, want.value,
							rsp.success, rsp.status, rsp.written_value);
					bad_beats++;
				end
			end
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n           = 1'b0;
		steady           = 1'b0;
		bad_beats        = 0;
		req.valid        = 1'b0;
		req.opcode       = '0;
		req.first_mode   = '0;
		req.first_value  = '0;
		req.second_mode  = '0;
		req.second_value = '0;
		foreach (reg_shadow[i])
			reg_shadow[i] = '0;
		foreach (mem_shadow[i])
			mem_shadow[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_moves();
		test_arith_wrap();
		test_divide();
		wait_all_results();
		test_bad_operands();
		test_bad_opcodes();
		wait_all_results();
		test_random_mix(450);
		wait_all_results();
		test_random_mix(450);
		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (bad_beats == 0 && pending_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
